/* rtl/cpc_pkg.sv */
// ----------------------------------------------------------------------------
// cpc_pkg
// Shared types, widths and constant tables for the compass polar to
// cartesian converter.
// ----------------------------------------------------------------------------
`default_nettype none

package cpc_pkg;

  localparam int DEF_ROTATION_STAGES = 18;
  localparam int MAX_ROTATION_STAGES = 32;

  localparam int AZ_W    = 16;
  localparam int DIST_W  = 16;
  localparam int OUT_W   = 17;
  localparam int REM_W   = 13;
  localparam int ANGLE_W = 32;
  localparam int VEC_W   = 42;
  localparam int FRAC_W  = 24;
  localparam int GAIN_W  = 24;
  localparam int PROD_W  = 27;
  localparam int QUO_W   = 7;
  localparam int MOD_W   = 6;
  localparam int ZTAB_W  = 23;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;

  localparam logic [AZ_W-2:0] QUARTER_UNITS = 15'd5760;
  localparam logic [AZ_W-2:0] HALF_UNITS    = 15'd11520;
  localparam logic [AZ_W-2:0] THREE_Q_UNITS = 15'd17280;
  localparam logic [AZ_W-2:0] FULL_UNITS    = 15'd23040;

  localparam logic [GAIN_W-1:0] GAIN_Q24 = 24'd10188014;

  // The quarter remainder r maps to r * 2^23 / 45 turns; r / 45 uses a
  // reciprocal that is exact for every 13-bit remainder.
  localparam int ANGLE_DIVISOR = 45;
  localparam logic [PROD_W-1:0] RECIP_45 = 27'd11651;
  localparam int RECIP_SHIFT = 19;

  localparam logic signed [OUT_W-1:0] OUT_LIMIT = 17'sd65535;

  typedef enum logic [1:0] {
    QUAD_NE = 2'd0,
    QUAD_SE = 2'd1,
    QUAD_SW = 2'd2,
    QUAD_NW = 2'd3
  } quad_t;

  typedef struct packed {
    logic  valid;
    logic  ok;
    quad_t quad;
  } cpc_meta_t;

  typedef struct packed {
    logic                    in_range;
    logic signed [OUT_W-1:0] y_offset;
    logic signed [OUT_W-1:0] x_offset;
  } cpc_result_t;

  typedef logic [ZTAB_W-1:0] ztab_t [ANGLE_DIVISOR];

  function automatic ztab_t build_ztab();
    ztab_t t;
    for (int b = 0; b < ANGLE_DIVISOR; b++) begin
      t[b] = ZTAB_W'(((longint'(b) <<< 23) + 64'sd22) / ANGLE_DIVISOR);
    end
    return t;
  endfunction

  localparam ztab_t ZTAB = build_ztab();

  localparam logic [ANGLE_W-1:0] ATAN_TURNS [MAX_ROTATION_STAGES] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2E, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000002, 32'h00000001, 32'h00000000, 32'h00000000
  };

endpackage

`default_nettype wire

/* rtl/cpc_front.sv */
// ----------------------------------------------------------------------------
// cpc_front
// Four-stage front end: range check and quadrant fold, gain and reciprocal
// multiplies, split by 45, and the binary angle of the in-quadrant remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_front
  import cpc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  wire logic                     in_valid,
  input  wire logic signed [AZ_W-1:0]   azimuth,
  input  wire logic [DIST_W-1:0]        range_value,
  output cpc_meta_t                     meta,
  output logic signed [VEC_W-1:0]       x0,
  output logic signed [ANGLE_W-1:0]     z0
);

  cpc_meta_t meta1, meta2, meta3;
  logic [REM_W-1:0] rem1, rem2;
  logic [DIST_W-1:0] dist1;
  logic [PROD_W-1:0] prod2;
  logic [VEC_W-1:0] gain2, gain3;
  logic [QUO_W-1:0] quo3;
  logic [MOD_W-1:0] mod3;

  logic              ok_c;
  quad_t             quad_c;
  logic [AZ_W-2:0]   base_c;
  logic [QUO_W-1:0]  quo_c;

  always_comb begin
    ok_c   = !azimuth[AZ_W-1] && (azimuth[AZ_W-2:0] <= FULL_UNITS);
    quad_c = QUAD_NE;
    base_c = '0;
    if (azimuth[AZ_W-2:0] == FULL_UNITS) begin
      quad_c = QUAD_NE;
      base_c = FULL_UNITS;
    end else if (azimuth[AZ_W-2:0] >= THREE_Q_UNITS) begin
      quad_c = QUAD_NW;
      base_c = THREE_Q_UNITS;
    end else if (azimuth[AZ_W-2:0] >= HALF_UNITS) begin
      quad_c = QUAD_SW;
      base_c = HALF_UNITS;
    end else if (azimuth[AZ_W-2:0] >= QUARTER_UNITS) begin
      quad_c = QUAD_SE;
      base_c = QUARTER_UNITS;
    end
    quo_c = prod2[RECIP_SHIFT +: QUO_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      meta1 <= '0;
      meta2 <= '0;
      meta3 <= '0;
      meta  <= '0;
    end else if (en) begin
      meta1.valid <= in_valid;
      meta1.ok    <= ok_c;
      meta1.quad  <= quad_c;
      meta2       <= meta1;
      meta3       <= meta2;
      meta        <= meta3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem1  <= REM_W'(azimuth[AZ_W-2:0] - base_c);
      dist1 <= range_value;
      rem2  <= rem1;
      prod2 <= PROD_W'(rem1) * RECIP_45;
      gain2 <= VEC_W'(dist1) * VEC_W'(GAIN_Q24);
      gain3 <= gain2;
      quo3  <= quo_c;
      mod3  <= MOD_W'(rem2 - REM_W'(quo_c * REM_W'(ANGLE_DIVISOR)));
      x0    <= signed'(gain3);
      z0    <= signed'(ANGLE_W'({quo3, {ZTAB_W{1'b0}}}) + ANGLE_W'(ZTAB[mod3]));
    end
  end

endmodule

`default_nettype wire

/* rtl/cpc_cell.sv */
// ----------------------------------------------------------------------------
// cpc_cell
// One micro-rotation of the rotator: turns the vector by the arctangent of
// 2^-STAGE toward the residual angle and hands the result to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_cell
  import cpc_pkg::*;
#(
  parameter int STAGE = 0
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     en,
  input  cpc_meta_t                     meta_in,
  input  wire logic signed [VEC_W-1:0]  x_in,
  input  wire logic signed [VEC_W-1:0]  y_in,
  input  wire logic signed [ANGLE_W-1:0] z_in,
  output cpc_meta_t                     meta_out,
  output logic signed [VEC_W-1:0]       x_out,
  output logic signed [VEC_W-1:0]       y_out,
  output logic signed [ANGLE_W-1:0]     z_out
);

  localparam logic signed [ANGLE_W-1:0] ATAN = signed'(ATAN_TURNS[STAGE]);

  logic signed [VEC_W-1:0] dx, dy;

  assign dx = y_in >>> STAGE;
  assign dy = x_in >>> STAGE;

  always_ff @(posedge clk) begin
    if (rst) begin
      meta_out <= '0;
    end else if (en) begin
      meta_out <= meta_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!z_in[ANGLE_W-1]) begin
        x_out <= x_in - dx;
        y_out <= y_in + dy;
        z_out <= z_in - ATAN;
      end else begin
        x_out <= x_in + dx;
        y_out <= y_in - dy;
        z_out <= z_in + ATAN;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/cpc_back.sv */
// ----------------------------------------------------------------------------
// cpc_back
// Rounds and saturates the rotated vector, then maps it to screen offsets
// by quadrant and clears the result for an azimuth out of range.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_back
  import cpc_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    en,
  input  cpc_meta_t                    meta,
  input  wire logic signed [VEC_W-1:0] x_in,
  input  wire logic signed [VEC_W-1:0] y_in,
  output logic                         out_valid,
  output cpc_result_t                  result
);

  localparam int RND_W = VEC_W - FRAC_W;

  function automatic logic signed [OUT_W-1:0] round_sat(logic signed [VEC_W-1:0] v);
    logic signed [VEC_W-1:0] s;
    logic signed [RND_W-1:0] t;
    s = v + (VEC_W'(1) <<< (FRAC_W - 1));
    t = s[VEC_W-1:FRAC_W];
    if (t > RND_W'(OUT_LIMIT)) begin
      return OUT_LIMIT;
    end else if (t < -RND_W'(OUT_LIMIT)) begin
      return -OUT_LIMIT;
    end
    return OUT_W'(t);
  endfunction

  logic signed [OUT_W-1:0] c, s;
  cpc_result_t res_c;

  always_comb begin
    c = round_sat(x_in);
    s = round_sat(y_in);
    res_c = '0;
    if (meta.ok) begin
      res_c.in_range = 1'b1;
      unique case (meta.quad)
        QUAD_NE: begin
          res_c.x_offset = s;
          res_c.y_offset = -c;
        end
        QUAD_SE: begin
          res_c.x_offset = c;
          res_c.y_offset = s;
        end
        QUAD_SW: begin
          res_c.x_offset = -s;
          res_c.y_offset = c;
        end
        default: begin
          res_c.x_offset = -c;
          res_c.y_offset = -s;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= meta.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= res_c;
    end
  end

endmodule

`default_nettype wire

/* rtl/compass_polar_to_cartesian.sv */
// ----------------------------------------------------------------------------
// compass_polar_to_cartesian
// Converts a compass azimuth and a distance to screen offsets
// x = d*sin(az), y = -d*cos(az) with a pipelined chain of rotation cells.
// ----------------------------------------------------------------------------
// Channel  Dir  Width  Contents (lowest bit first)
// s_       in   32     azimuth[15:0], range_value[31:16]
// m_       out  40     x_offset[16:0], y_offset[33:17], in_range[34], zero
//
// One word is taken per cycle while s_tready is high; a result passes through
// the four front stages, one register per rotation cell, the rounding stage
// and the output register.
// Reset clears all valid flags; no clearing pass is needed.
// A two-entry output buffer keeps s_tready independent of m_tready; the
// pipeline stalls only while both entries are full.
// ----------------------------------------------------------------------------
`default_nettype none

module compass_polar_to_cartesian
  import cpc_pkg::*;
#(
  parameter int ROTATION_STAGES = DEF_ROTATION_STAGES
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  // azimuth[15:0], range_value[31:16]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  // x_offset[16:0], y_offset[33:17], in_range[34], zeros[39:35]
  output logic [OUT_DATA_W-1:0]      m_tdata
);

  localparam int N = ROTATION_STAGES;

  logic en;
  cpc_meta_t               meta_chain [N+1];
  logic signed [VEC_W-1:0] x_chain    [N+1];
  logic signed [VEC_W-1:0] y_chain    [N+1];
  logic signed [ANGLE_W-1:0] z_chain  [N+1];

  logic        pipe_valid;
  cpc_result_t pipe_result;
  logic        skid_valid;
  cpc_result_t skid_result;
  cpc_result_t out_result;

  assign en       = !skid_valid;
  assign s_tready = en;

  cpc_front u_front (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_valid    (s_tvalid),
    .azimuth     (signed'(s_tdata[AZ_W-1:0])),
    .range_value (s_tdata[AZ_W +: DIST_W]),
    .meta        (meta_chain[0]),
    .x0          (x_chain[0]),
    .z0          (z_chain[0])
  );

  assign y_chain[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    cpc_cell #(
      .STAGE (i)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .meta_in  (meta_chain[i]),
      .x_in     (x_chain[i]),
      .y_in     (y_chain[i]),
      .z_in     (z_chain[i]),
      .meta_out (meta_chain[i+1]),
      .x_out    (x_chain[i+1]),
      .y_out    (y_chain[i+1]),
      .z_out    (z_chain[i+1])
    );
  end

  cpc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .meta      (meta_chain[N]),
    .x_in      (x_chain[N]),
    .y_in      (y_chain[N]),
    .out_valid (pipe_valid),
    .result    (pipe_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= pipe_valid;
      end
    end else if (pipe_valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      out_result <= skid_valid ? skid_result : pipe_result;
    end else if (!skid_valid) begin
      skid_result <= pipe_result;
    end
  end

  assign m_tdata = OUT_DATA_W'(out_result);

endmodule

`default_nettype wire

/* rtl/cpc_check.sv */
// ----------------------------------------------------------------------------
// cpc_check
// Port-level checks for the compass polar to cartesian converter, bound to
// the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_check
  import cpc_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  m_tvalid,
  input wire logic                  m_tready,
  input wire logic [OUT_DATA_W-1:0] m_tdata
);

  localparam int IN_RANGE_BIT = 2 * OUT_W;

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  a_zero_when_out: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[IN_RANGE_BIT] |-> m_tdata[IN_RANGE_BIT-1:0] == '0)
    else $error("nonzero offsets for an azimuth out of range");

  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_DATA_W-1:IN_RANGE_BIT+1] == '0)
    else $error("padding bits of output word not zero");

  a_saturated: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[OUT_W-1:0] != {1'b1, {(OUT_W-1){1'b0}}} &&
                 m_tdata[2*OUT_W-1:OUT_W] != {1'b1, {(OUT_W-1){1'b0}}})
    else $error("offset outside the saturation limits");

endmodule

bind compass_polar_to_cartesian cpc_check u_cpc_check (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
